// File: design/otcs_pkg.sv
package otcs_pkg;

	localparam int MAX_CHARS   = 15;
	localparam int GLYPH_BYTES = 16;
	localparam int NUM_GLYPHS  = 18;
	localparam int ROM_DEPTH   = NUM_GLYPHS * GLYPH_BYTES;
	localparam int ROM_AW      = $clog2(ROM_DEPTH);
	localparam int GLYPH_W     = $clog2(NUM_GLYPHS);
	localparam int OFFS_W      = $clog2(GLYPH_BYTES);

	// beat numbers within one character
	localparam logic [4:0] BEAT_COL_CMD  = 5'd0;
	localparam logic [4:0] BEAT_COL_LO   = 5'd1;
	localparam logic [4:0] BEAT_COL_HI   = 5'd2;
	localparam logic [4:0] BEAT_PAGE_CMD = 5'd3;
	localparam logic [4:0] BEAT_PAGE_LO  = 5'd4;
	localparam logic [4:0] BEAT_PAGE_HI  = 5'd5;
	localparam logic [4:0] BEAT_DATA     = 5'd6;
	localparam logic [4:0] BEAT_LAST     = 5'(6 + GLYPH_BYTES - 1);

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_BAD_LINE = 2'd1;
	localparam logic [1:0] ERR_TOO_MANY = 2'd2;

	localparam logic [1:0] CFG_COLUMN_COMMAND = 2'd0;
	localparam logic [1:0] CFG_PAGE_COMMAND   = 2'd1;
	localparam logic [1:0] CFG_CHAR_SPACING   = 2'd2;
	localparam logic [1:0] CFG_START_MARGIN   = 2'd3;

	localparam logic [GLYPH_W-1:0] GLYPH_BLANK = GLYPH_W'(0);
	localparam logic [GLYPH_W-1:0] GLYPH_BLOCK = GLYPH_W'(17);

	typedef struct packed {
		logic [7:0] char_code;
		logic [2:0] line_number;
		logic       first_of_string;
	} in_item_t;

	typedef struct packed {
		logic       is_data;
		logic [7:0] byte_value;
		logic       last;
		logic [1:0] error_code;
		logic [7:0] next_margin;
	} out_item_t;

	typedef struct packed {
		logic [1:0]         err;
		logic [7:0]         margin;
		logic [7:0]         next;
		logic [2:0]         line;
		logic [GLYPH_W-1:0] glyph;
	} job_t;

	localparam logic [7:0] FONT [ROM_DEPTH] = '{
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd248, 8'd252, 8'd14, 8'd134, 8'd134, 8'd14, 8'd252, 8'd248,
		8'd63, 8'd127, 8'd224, 8'd195, 8'd195, 8'd224, 8'd127, 8'd63,
		8'd12, 8'd12, 8'd12, 8'd254, 8'd254, 8'd0, 8'd0, 8'd0,
		8'd192, 8'd192, 8'd192, 8'd255, 8'd255, 8'd192, 8'd192, 8'd192,
		8'd0, 8'd28, 8'd12, 8'd6, 8'd6, 8'd142, 8'd254, 8'd248,
		8'd224, 8'd240, 8'd248, 8'd220, 8'd207, 8'd199, 8'd195, 8'd192,
		8'd28, 8'd12, 8'd142, 8'd134, 8'd134, 8'd206, 8'd252, 8'd120,
		8'd112, 8'd224, 8'd193, 8'd193, 8'd193, 8'd231, 8'd127, 8'd60,
		8'd128, 8'd252, 8'd124, 8'd0, 8'd0, 8'd254, 8'd254, 8'd0,
		8'd15, 8'd15, 8'd12, 8'd12, 8'd12, 8'd255, 8'd255, 8'd12,
		8'd0, 8'd254, 8'd254, 8'd134, 8'd134, 8'd134, 8'd6, 8'd0,
		8'd56, 8'd121, 8'd225, 8'd193, 8'd193, 8'd227, 8'd127, 8'd30,
		8'd224, 8'd248, 8'd156, 8'd134, 8'd134, 8'd134, 8'd6, 8'd0,
		8'd63, 8'd127, 8'd225, 8'd193, 8'd193, 8'd227, 8'd63, 8'd30,
		8'd62, 8'd62, 8'd6, 8'd6, 8'd6, 8'd246, 8'd254, 8'd14,
		8'd0, 8'd0, 8'd0, 8'd240, 8'd255, 8'd15, 8'd0, 8'd0,
		8'd56, 8'd124, 8'd206, 8'd134, 8'd134, 8'd206, 8'd124, 8'd56,
		8'd62, 8'd127, 8'd227, 8'd193, 8'd193, 8'd227, 8'd127, 8'd62,
		8'd240, 8'd252, 8'd142, 8'd6, 8'd6, 8'd14, 8'd252, 8'd248,
		8'd0, 8'd193, 8'd195, 8'd195, 8'd195, 8'd115, 8'd63, 8'd15,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd48, 8'd176, 8'd112, 8'd0, 8'd0, 8'd0,
		8'd248, 8'd252, 8'd14, 8'd6, 8'd6, 8'd14, 8'd12, 8'd0,
		8'd63, 8'd127, 8'd224, 8'd192, 8'd192, 8'd224, 8'd96, 8'd32,
		8'd12, 8'd50, 8'd50, 8'd12, 8'd192, 8'd240, 8'd62, 8'd14,
		8'd192, 8'd240, 8'd60, 8'd15, 8'd99, 8'd152, 8'd152, 8'd96,
		8'd0, 8'd24, 8'd60, 8'd102, 8'd102, 8'd60, 8'd24, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd254, 8'd254, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0,
		8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
	};

	function automatic logic [GLYPH_W-1:0] pick_glyph(input logic [7:0] code);
		logic [GLYPH_W-1:0] g;
		g = GLYPH_BLOCK;
		if (code == 8'd32 || code == 8'd0) begin
			g = GLYPH_BLANK;
		end else if (code >= 8'd48 && code <= 8'd57) begin
			g = GLYPH_W'(code - 8'd47);
		end else begin
			unique case (code)
				8'd45:   g = GLYPH_W'(11);
				8'd44:   g = GLYPH_W'(12);
				8'd67:   g = GLYPH_W'(13);
				8'd37:   g = GLYPH_W'(14);
				8'd167:  g = GLYPH_W'(15);
				8'd179:  g = GLYPH_W'(16);
				default: g = GLYPH_BLOCK;
			endcase
		end
		return g;
	endfunction

endpackage

// File: design/otcs_glyph_rom.sv
module otcs_glyph_rom (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [otcs_pkg::ROM_AW-1:0] rd_addr,
	output logic [7:0]                  rd_data
);

	// registered synchronous read; hold data when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= otcs_pkg::FONT[rd_addr];
		end
	end

endmodule

// File: design/oled_text_command_stream.sv
// Text renderer for an OLED controller byte stream.
// Input channel (in_valid/in_ready, in_item): one character per item with its
// text line (1..7) and a start-of-string mark.
// Output channel (out_valid/out_ready, out_item): the bytes for the display.
// A drawn character yields 22 items: column command, margin, margin+7, page
// command, line-1, line, then 16 glyph data bytes, the final one marked last.
// A bad line number or a character past the fifteenth in a string yields one
// error item instead.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// writes column command, page command, spacing and start margin.
// The first byte passes through the job register and then the output register.
// The output carries one byte per cycle while out_ready holds high; the next
// item is taken in the cycle the current one issues its final byte, so
// characters stream without gaps.
// The glyph font sits in a 288-byte ROM with a registered read.
// Reset: registers return to defaults, margin 1, count 0, both channels empty.
// Stall: when out_ready is low with a byte waiting, the output register, ROM data
// and beat counter hold; input is refused while a job is held short of its last byte.
module oled_text_command_stream (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  otcs_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output otcs_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data
);

	// configuration registers
	logic [7:0] column_command_q;
	logic [7:0] page_command_q;
	logic [4:0] char_spacing_q;
	logic [6:0] start_margin_q;

	// running string state
	logic [7:0] margin_q;
	logic [4:0] count_q;

	// job register: the character being emitted
	logic             job_valid_q;
	otcs_pkg::job_t   job_q;
	logic [4:0]       beat_q;

	// output stage
	logic       out_valid_s2;
	logic       is_data_s2;
	logic [7:0] byte_s2;
	logic       last_s2;
	logic [1:0] err_s2;
	logic [7:0] next_s2;
	logic [7:0] rom_data;

	logic                          in_fire;
	logic                          advance;
	logic                          issue;
	logic                          job_last_beat;
	logic [7:0]                    eff_margin;
	logic [4:0]                    eff_count;
	otcs_pkg::job_t                new_job;
	logic [otcs_pkg::ROM_AW-1:0]   rom_addr;
	logic [otcs_pkg::OFFS_W-1:0]   data_offs;
	logic [7:0]                    beat_byte;
	logic                          beat_is_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_command_q <= 8'd33;
			page_command_q   <= 8'd34;
			char_spacing_q   <= 5'd9;
			start_margin_q   <= 7'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				otcs_pkg::CFG_COLUMN_COMMAND: column_command_q <= cfg_data;
				otcs_pkg::CFG_PAGE_COMMAND:   page_command_q   <= cfg_data;
				otcs_pkg::CFG_CHAR_SPACING:   char_spacing_q   <= cfg_data[4:0];
				otcs_pkg::CFG_START_MARGIN:   start_margin_q   <= cfg_data[6:0];
			endcase
		end
	end

	// Output register advances when empty or drained this cycle.
	assign advance       = !out_valid_s2 || out_ready;
	assign issue         = job_valid_q && advance;
	assign job_last_beat = (job_q.err != otcs_pkg::ERR_NONE) || (beat_q == otcs_pkg::BEAT_LAST);
	assign in_ready      = !job_valid_q || (issue && job_last_beat);
	assign in_fire       = in_valid && in_ready;

	// Start of string reloads margin and count before any check.
	assign eff_margin = in_item.first_of_string ? {1'b0, start_margin_q} : margin_q;
	assign eff_count  = in_item.first_of_string ? 5'd0 : count_q;

	always_comb begin
		new_job.margin = eff_margin;
		new_job.next   = eff_margin;
		new_job.line   = in_item.line_number;
		new_job.glyph  = otcs_pkg::pick_glyph(in_item.char_code);
		// bad line number wins over too many characters
		if (in_item.line_number == 3'd0) begin
			new_job.err = otcs_pkg::ERR_BAD_LINE;
		end else if (eff_count >= 5'(otcs_pkg::MAX_CHARS)) begin
			new_job.err = otcs_pkg::ERR_TOO_MANY;
		end else begin
			new_job.err  = otcs_pkg::ERR_NONE;
			new_job.next = eff_margin + {3'd0, char_spacing_q};
		end
	end

	// Update string state at accept so the next item sees it at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= 8'd1;
			count_q  <= 5'd0;
		end else if (in_fire) begin
			margin_q <= new_job.next;
			if (new_job.err == otcs_pkg::ERR_NONE) begin
				count_q <= eff_count + 5'd1;
			end else begin
				count_q <= eff_count;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			beat_q      <= 5'd0;
		end else if (in_fire) begin
			job_valid_q <= 1'b1;
			beat_q      <= 5'd0;
		end else if (issue) begin
			if (job_last_beat) begin
				job_valid_q <= 1'b0;
			end else begin
				beat_q <= beat_q + 5'd1;
			end
		end
	end

	// job payload needs no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			job_q <= new_job;
		end
	end

	// Select the command byte for this beat; data beats come from the ROM.
	always_comb begin
		beat_byte    = 8'd0;
		beat_is_data = 1'b0;
		if (job_q.err == otcs_pkg::ERR_NONE) begin
			unique case (beat_q)
				otcs_pkg::BEAT_COL_CMD:  beat_byte = column_command_q;
				otcs_pkg::BEAT_COL_LO:   beat_byte = job_q.margin;
				otcs_pkg::BEAT_COL_HI:   beat_byte = job_q.margin + 8'd7;
				otcs_pkg::BEAT_PAGE_CMD: beat_byte = page_command_q;
				otcs_pkg::BEAT_PAGE_LO:  beat_byte = {5'd0, job_q.line - 3'd1};
				otcs_pkg::BEAT_PAGE_HI:  beat_byte = {5'd0, job_q.line};
				default:                 beat_is_data = 1'b1;
			endcase
		end
	end

	assign data_offs = otcs_pkg::OFFS_W'(beat_q - otcs_pkg::BEAT_DATA);
	assign rom_addr  = {job_q.glyph, data_offs};

	otcs_glyph_rom u_rom (
		.clk     (clk),
		.rd_en   (issue),
		.rd_addr (rom_addr),
		.rd_data (rom_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			is_data_s2 <= beat_is_data;
			byte_s2    <= beat_byte;
			last_s2    <= job_last_beat;
			err_s2     <= job_q.err;
			next_s2    <= job_q.next;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_item  = '{
		is_data:     is_data_s2,
		byte_value:  is_data_s2 ? rom_data : byte_s2,
		last:        last_s2,
		error_code:  err_s2,
		next_margin: next_s2
	};

endmodule
